@@ src/ipv6ctf_pkg.sv @@
// Shared types, constants and helper functions of the IPv6 text formatter.
// Used by the front, queue and back modules and by the top level; no dependencies.

package ipv6ctf_pkg;

  localparam int QDEPTH = 2;
  localparam int QCNT_W = 2;
  localparam int QPTR_W = 1;

  localparam logic [6:0] CH_COLON = 7'h3a;
  localparam logic [6:0] CH_DOT   = 7'h2e;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_HEXA  = 7'h57;

  typedef struct packed {
    logic [127:0] addr;
    logic         plain;
    logic         v4;
    logic [2:0]   best_pos;
    logic [3:0]   best_len;
  } desc_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_CMP2,
    ST_SEP,
    ST_HEX,
    ST_TSEP,
    ST_DEC,
    ST_DOT
  } emit_state_t;

  function automatic logic [15:0] group_of(input logic [127:0] a, input logic [2:0] g);
    logic [2:0] s;
    begin
      s = 3'd7 - g;
      return a[{s, 4'b0000} +: 16];
    end
  endfunction

  function automatic logic [7:0] octet_of(input logic [127:0] a, input logic [1:0] k);
    logic [1:0] s;
    logic [31:0] w;
    begin
      s = 2'd3 - k;
      w = a[31:0];
      return w[{s, 3'b000} +: 8];
    end
  endfunction

  function automatic logic [1:0] lead_nib(input logic [15:0] v);
    begin
      if (v[15:12] != 4'd0) return 2'd3;
      else if (v[11:8] != 4'd0) return 2'd2;
      else if (v[7:4] != 4'd0) return 2'd1;
      else return 2'd0;
    end
  endfunction

  function automatic logic [1:0] lead_dig(input logic [7:0] v);
    begin
      if (v >= 8'd100) return 2'd2;
      else if (v >= 8'd10) return 2'd1;
      else return 2'd0;
    end
  endfunction

  function automatic logic [6:0] hex_char(input logic [3:0] d);
    begin
      if (d < 4'd10) return CH_ZERO + {3'b000, d};
      else return CH_HEXA + {3'b000, d};
    end
  endfunction

  // Decimal digits of an octet by reciprocal multiplication.
  function automatic logic [3:0] dec_digit(input logic [7:0] v, input logic [1:0] pos);
    logic [15:0] p10;
    logic [4:0]  q10;
    logic [13:0] p100;
    logic [12:0] pt;
    logic [4:0]  tens;
    logic [7:0]  ones;
    begin
      p10  = {8'd0, v} * 16'd205;
      q10  = p10[15:11];
      p100 = {6'd0, v} * 14'd41;
      pt   = {8'd0, q10} * 13'd205;
      tens = q10 - 5'd10 * {3'b000, pt[12:11]};
      ones = v - 8'd10 * {3'b000, q10};
      case (pos)
        2'd2:    return {2'b00, p100[13:12]};
        2'd1:    return tens[3:0];
        default: return ones[3:0];
      endcase
    end
  endfunction

endpackage

@@ src/ipv6ctf_front.sv @@
// Front end: holds the mode register, accepts addresses and classifies them.
// Finds the v4 forms and the longest zero-group run; depends on ipv6ctf_pkg.

module ipv6ctf_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [127:0]           in_tdata,
  input  logic                   q_full,
  output logic                   push,
  output ipv6ctf_pkg::desc_t     push_desc
);

  logic         cfg_r;
  logic         cfg_nxt;
  logic [63:0]  hi;
  logic [63:0]  lo;
  logic [127:0] addr;
  logic         top_zero;
  logic         mapped;
  logic         compat;
  logic         v4;
  logic [2:0]   run_pos;
  logic [3:0]   run_len;
  logic [2:0]   best_pos;
  logic [3:0]   best_len;

  function automatic logic group_is_zero(input logic [127:0] a, input logic [2:0] g);
    begin
      return ipv6ctf_pkg::group_of(a, g) == 16'd0;
    end
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_nxt   = (cfg_valid && cfg_ready) ? cfg_data : cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign hi       = in_tdata[63:0];
  assign lo       = in_tdata[127:64];
  assign addr     = {hi, lo};
  assign top_zero = (hi == 64'd0) && (lo[63:48] == 16'd0);
  assign mapped   = top_zero && (lo[47:32] == 16'hffff);
  assign compat   = top_zero && (lo[47:32] == 16'd0) && (lo[31:24] != 8'd0);
  assign v4       = mapped || compat;

  always_comb begin
    run_pos  = 3'd0;
    run_len  = 4'd0;
    best_pos = 3'd0;
    best_len = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (!(v4 && i >= 6)) begin
        if (group_is_zero(addr, 3'(i))) begin
          if (run_len == 4'd0) run_pos = 3'(i);
          run_len = run_len + 4'd1;
          if (run_len >= 4'd2 && run_len > best_len) begin
            best_len = run_len;
            best_pos = run_pos;
          end
        end else begin
          run_len = 4'd0;
        end
      end
    end
  end

  assign in_tready          = !q_full;
  assign push               = in_tvalid && in_tready;
  assign push_desc.addr     = addr;
  assign push_desc.plain    = mapped && cfg_r;
  assign push_desc.v4       = v4;
  assign push_desc.best_pos = best_pos;
  assign push_desc.best_len = best_len;

endmodule

@@ src/ipv6ctf_queue.sv @@
// Short descriptor queue between the front and back ends.
// Register-based FIFO of ipv6ctf_pkg::desc_t entries; depends on ipv6ctf_pkg.

module ipv6ctf_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  ipv6ctf_pkg::desc_t                  push_desc,
  input  logic                                pop,
  output ipv6ctf_pkg::desc_t                  head,
  output logic [ipv6ctf_pkg::QCNT_W-1:0]      cnt,
  output logic                                full,
  output logic                                empty
);

  ipv6ctf_pkg::desc_t                 mem_r [ipv6ctf_pkg::QDEPTH];
  logic [ipv6ctf_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [ipv6ctf_pkg::QPTR_W-1:0]     wr_ptr_nxt;
  logic [ipv6ctf_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [ipv6ctf_pkg::QPTR_W-1:0]     rd_ptr_nxt;
  logic [ipv6ctf_pkg::QCNT_W-1:0]     cnt_r;
  logic [ipv6ctf_pkg::QCNT_W-1:0]     cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign cnt   = cnt_r;
  assign full  = (cnt_r == ipv6ctf_pkg::QCNT_W'(ipv6ctf_pkg::QDEPTH));
  assign empty = (cnt_r == '0);

endmodule

@@ src/ipv6ctf_back.sv @@
// Back end: walks one classified address and emits its text one character per item.
// Holds the character sequencer and the output register; depends on ipv6ctf_pkg.

module ipv6ctf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  ipv6ctf_pkg::desc_t   head,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tlast
);

  ipv6ctf_pkg::emit_state_t st_r, st_nxt;
  logic [127:0] addr_r, addr_nxt;
  logic         v4_r, v4_nxt;
  logic [2:0]   bpos_r, bpos_nxt;
  logic [3:0]   blen_r, blen_nxt;
  logic [2:0]   grp_r, grp_nxt;
  logic [1:0]   nib_r, nib_nxt;
  logic [1:0]   oct_r, oct_nxt;
  logic [1:0]   dig_r, dig_nxt;
  logic         ov_r, ov_nxt;
  logic [6:0]   och_r, och_nxt;
  logic         olast_r, olast_nxt;

  logic         adv;
  logic         emit;
  logic [6:0]   ch;
  logic         last;
  logic [3:0]   n;
  logic [3:0]   j;
  logic [15:0]  grp_val;
  logic [7:0]   oct_val;

  assign adv     = !ov_r || out_tready;
  assign n       = v4_r ? 4'd6 : 4'd8;
  assign j       = {1'b0, grp_r} + 4'd1;
  assign grp_val = ipv6ctf_pkg::group_of(addr_r, grp_r);
  assign oct_val = ipv6ctf_pkg::octet_of(addr_r, oct_r);

  always_comb begin
    st_nxt   = st_r;
    addr_nxt = addr_r;
    v4_nxt   = v4_r;
    bpos_nxt = bpos_r;
    blen_nxt = blen_r;
    grp_nxt  = grp_r;
    nib_nxt  = nib_r;
    oct_nxt  = oct_r;
    dig_nxt  = dig_r;
    emit     = 1'b0;
    ch       = ipv6ctf_pkg::CH_COLON;
    last     = 1'b0;
    pop      = 1'b0;
    case (st_r)
      ipv6ctf_pkg::ST_IDLE: begin
        if (!q_empty) begin
          pop      = 1'b1;
          addr_nxt = head.addr;
          v4_nxt   = head.v4;
          bpos_nxt = head.best_pos;
          blen_nxt = head.best_len;
          grp_nxt  = 3'd0;
          oct_nxt  = 2'd0;
          dig_nxt  = ipv6ctf_pkg::lead_dig(ipv6ctf_pkg::octet_of(head.addr, 2'd0));
          nib_nxt  = ipv6ctf_pkg::lead_nib(ipv6ctf_pkg::group_of(head.addr, 3'd0));
          if (head.plain) begin
            st_nxt = ipv6ctf_pkg::ST_DEC;
          end else if (head.best_len != 4'd0 && head.best_pos == 3'd0) begin
            st_nxt = ipv6ctf_pkg::ST_CMP;
          end else begin
            st_nxt = ipv6ctf_pkg::ST_HEX;
          end
        end
      end
      ipv6ctf_pkg::ST_CMP: begin
        if (adv) begin
          emit = 1'b1;
          if (blen_r == n - {1'b0, grp_r}) begin
            st_nxt = ipv6ctf_pkg::ST_CMP2;
          end else begin
            grp_nxt  = grp_r + blen_r[2:0];
            blen_nxt = 4'd0;
            st_nxt   = ipv6ctf_pkg::ST_SEP;
          end
        end
      end
      ipv6ctf_pkg::ST_CMP2: begin
        if (adv) begin
          emit = 1'b1;
          if (v4_r) begin
            oct_nxt = 2'd0;
            dig_nxt = ipv6ctf_pkg::lead_dig(ipv6ctf_pkg::octet_of(addr_r, 2'd0));
            st_nxt  = ipv6ctf_pkg::ST_DEC;
          end else begin
            last   = 1'b1;
            st_nxt = ipv6ctf_pkg::ST_IDLE;
          end
        end
      end
      ipv6ctf_pkg::ST_SEP: begin
        if (adv) begin
          emit    = 1'b1;
          nib_nxt = ipv6ctf_pkg::lead_nib(grp_val);
          st_nxt  = ipv6ctf_pkg::ST_HEX;
        end
      end
      ipv6ctf_pkg::ST_HEX: begin
        if (adv) begin
          emit = 1'b1;
          ch   = ipv6ctf_pkg::hex_char(grp_val[{nib_r, 2'b00} +: 4]);
          if (nib_r != 2'd0) begin
            nib_nxt = nib_r - 2'd1;
          end else if (j == n) begin
            if (v4_r) begin
              st_nxt = ipv6ctf_pkg::ST_TSEP;
            end else begin
              last   = 1'b1;
              st_nxt = ipv6ctf_pkg::ST_IDLE;
            end
          end else begin
            grp_nxt = j[2:0];
            if (blen_r != 4'd0 && j[2:0] == bpos_r) begin
              st_nxt = ipv6ctf_pkg::ST_CMP;
            end else begin
              st_nxt = ipv6ctf_pkg::ST_SEP;
            end
          end
        end
      end
      ipv6ctf_pkg::ST_TSEP: begin
        if (adv) begin
          emit    = 1'b1;
          oct_nxt = 2'd0;
          dig_nxt = ipv6ctf_pkg::lead_dig(ipv6ctf_pkg::octet_of(addr_r, 2'd0));
          st_nxt  = ipv6ctf_pkg::ST_DEC;
        end
      end
      ipv6ctf_pkg::ST_DEC: begin
        if (adv) begin
          emit = 1'b1;
          ch   = ipv6ctf_pkg::CH_ZERO + {3'b000, ipv6ctf_pkg::dec_digit(oct_val, dig_r)};
          if (dig_r != 2'd0) begin
            dig_nxt = dig_r - 2'd1;
          end else if (oct_r == 2'd3) begin
            last   = 1'b1;
            st_nxt = ipv6ctf_pkg::ST_IDLE;
          end else begin
            st_nxt = ipv6ctf_pkg::ST_DOT;
          end
        end
      end
      ipv6ctf_pkg::ST_DOT: begin
        if (adv) begin
          emit    = 1'b1;
          ch      = ipv6ctf_pkg::CH_DOT;
          oct_nxt = oct_r + 2'd1;
          dig_nxt = ipv6ctf_pkg::lead_dig(ipv6ctf_pkg::octet_of(addr_r, oct_r + 2'd1));
          st_nxt  = ipv6ctf_pkg::ST_DEC;
        end
      end
      default: begin
        st_nxt = ipv6ctf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_nxt    = ov_r;
    och_nxt   = och_r;
    olast_nxt = olast_r;
    if (emit) begin
      ov_nxt    = 1'b1;
      och_nxt   = ch;
      olast_nxt = last;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ipv6ctf_pkg::ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    v4_r    <= v4_nxt;
    bpos_r  <= bpos_nxt;
    blen_r  <= blen_nxt;
    grp_r   <= grp_nxt;
    nib_r   <= nib_nxt;
    oct_r   <= oct_nxt;
    dig_r   <= dig_nxt;
    och_r   <= och_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, och_r};
  assign out_tlast  = olast_r;

endmodule

@@ src/ipv6_canonical_text_formatter.sv @@
// Top level of the canonical IPv6 text formatter (RFC 5952 form).
// Instantiates ipv6ctf_front, ipv6ctf_queue and ipv6ctf_back; depends on ipv6ctf_pkg.
//
// Usage:
//   in_*  : one 128-bit address per item; in_tdata[63:0] holds octets 0-7,
//           in_tdata[127:64] octets 8-15, octet 0/8 in the top byte of each half.
//   out_* : one ASCII character per item in out_tdata[6:0], bit 7 zero;
//           out_tlast marks the final character of an address.
//   cfg_* : one-bit write of the mode register; 1 prints ffff-mapped
//           addresses as a bare dotted quad. Write only while idle.
// Path: an accepted address goes into the queue; a free sequencer loads it
//   from there and then puts its first character in the output register.
// Throughput: an address of C characters (2 to 39) holds the character
//   sequencer while it emits them, one character a cycle unless the receiver
//   stalls; it loads the next address from the queue in its idle state.
// A two-entry queue lets the front accept addresses while the back end
//   still emits; in_tready drops only when that queue is full.
// Reset: queue empty, sequencer idle, output empty, mode register cleared.
// Receiver stall: the output register holds its character and the
//   sequencer waits; input is taken until the queue fills.

module ipv6_canonical_text_formatter (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data,     // mapped_as_plain_ipv4
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,     // [63:0] addr_high, [127:64] addr_low
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata,    // [6:0] out_char, [7] zero
  output logic         out_tlast     // last_char
);

  ipv6ctf_pkg::desc_t                  push_desc;
  ipv6ctf_pkg::desc_t                  head;
  logic                                push;
  logic                                pop;
  logic                                q_full;
  logic                                q_empty;
  logic [ipv6ctf_pkg::QCNT_W-1:0]      q_cnt;

  ipv6ctf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  ipv6ctf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .cnt       (q_cnt),
    .full      (q_full),
    .empty     (q_empty)
  );

  ipv6ctf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= ipv6ctf_pkg::QCNT_W'(ipv6ctf_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_cnt != '0)
    else $error("pop from empty queue");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("output item changed while stalled");

endmodule
